// ===== design/ipc_mbx_pkg.sv =====
// ipc_mbx_pkg: shared types, codes and constants of the mailbox queue engine
// used by the front end, the back end and the top level; depends on nothing
`timescale 1ns / 1ps

package ipc_mbx_pkg;

  // defaults of the top-level parameters
  localparam int TASKS_DEF        = 32;
  localparam int QUEUE_DEPTH_DEF  = 32;
  localparam int PAYLOAD_BITS_DEF = 64;

  // task index width covering the largest task count
  localparam int TASK_IDX_W = 6;

  // opcodes
  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_RECV  = 3'd1;
  localparam logic [2:0] OP_POLL  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CAP   = 3'd1;
  localparam logic [2:0] ST_PTR   = 3'd2;
  localparam logic [2:0] ST_DEAD  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;
  localparam logic [2:0] ST_SAVED = 3'd6;

  // task states
  localparam logic [1:0] TS_RUN  = 2'd0;
  localparam logic [1:0] TS_WAIT = 2'd1;
  localparam logic [1:0] TS_DEAD = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DESKTOP   = 2'd0;
  localparam logic [1:0] REG_INPUT     = 2'd1;
  localparam logic [1:0] REG_DISPLAY   = 2'd2;
  localparam logic [1:0] REG_FIRST_APP = 2'd3;

  localparam logic [4:0] DESKTOP_RST   = 5'd0;
  localparam logic [4:0] INPUT_RST     = 5'd1;
  localparam logic [4:0] DISPLAY_RST   = 5'd2;
  localparam logic [4:0] FIRST_APP_RST = 5'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  caller_task;
    logic [5:0]  target_task;
    logic [31:0] buffer_address;
    logic        buffer_valid;
    logic        target_buffer_valid;
    logic [63:0] payload;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] msg_payload;
    logic [4:0]  msg_sender;
    logic        msg_valid;
    logic        caller_blocked;
    logic        woke_receiver;
    logic [4:0]  woke_task;
    logic [31:0] woke_address;
  } result_t;

  // request class decided by the front end
  typedef enum logic [2:0] {
    K_REJECT,
    K_SEND,
    K_RECV,
    K_POLL,
    K_START,
    K_END
  } kind_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t                 kind;
    logic [2:0]            early_status;
    logic [TASK_IDX_W-1:0] subject;
    logic [4:0]            caller;
    logic [31:0]           addr;
    logic                  tvalid;
    logic [63:0]           payload;
  } cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EXEC,
    BS_MSGRD
  } back_state_t;

endpackage

// ===== design/ipc_mbx_ram.sv =====
// ipc_mbx_ram: generic single-write, single-read RAM with registered read
// standalone; no package dependency
`timescale 1ns / 1ps

module ipc_mbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ipc_mbx_front.sv =====
// ipc_mbx_front: configuration registers, request classification and a
// two-entry command queue toward the back end; uses ipc_mbx_pkg
`timescale 1ns / 1ps

module ipc_mbx_front #(
  parameter int TASKS = ipc_mbx_pkg::TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ipc_mbx_pkg::request_t request,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  output logic                  cmd_valid,
  output ipc_mbx_pkg::cmd_t     cmd,
  input  logic                  cmd_take
);

  localparam logic [6:0] TASK_CNT = 7'(TASKS);

  logic [4:0] desktop_id, input_id, display_id, first_app_id;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      desktop_id   <= ipc_mbx_pkg::DESKTOP_RST;
      input_id     <= ipc_mbx_pkg::INPUT_RST;
      display_id   <= ipc_mbx_pkg::DISPLAY_RST;
      first_app_id <= ipc_mbx_pkg::FIRST_APP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ipc_mbx_pkg::REG_DESKTOP:   desktop_id   <= cfg_data;
        ipc_mbx_pkg::REG_INPUT:     input_id     <= cfg_data;
        ipc_mbx_pkg::REG_DISPLAY:   display_id   <= cfg_data;
        ipc_mbx_pkg::REG_FIRST_APP: first_app_id <= cfg_data;
      endcase
    end
  end

  // classification
  ipc_mbx_pkg::cmd_t cls;
  logic              caller_bad, target_bad, may_send;
  logic [6:0]        subj;

  always_comb begin
    caller_bad = {2'b00, request.caller_task} >= TASK_CNT;
    target_bad = {1'b0, request.target_task} >= TASK_CNT;
    may_send = ((request.caller_task == desktop_id) &&
                ((request.target_task == {1'b0, input_id}) ||
                 (request.target_task == {1'b0, display_id}))) ||
               (((request.caller_task == input_id) ||
                 (request.caller_task == display_id) ||
                 (request.caller_task >= first_app_id)) &&
                (request.target_task == {1'b0, desktop_id}));
    subj = (request.opcode == ipc_mbx_pkg::OP_SEND) ? {1'b0, request.target_task}
                                                     : {2'b00, request.caller_task};
    cls.early_status = ipc_mbx_pkg::ST_OK;
    cls.subject      = subj[ipc_mbx_pkg::TASK_IDX_W-1:0];
    cls.caller       = request.caller_task;
    cls.addr         = request.buffer_address;
    cls.tvalid       = request.target_buffer_valid;
    cls.payload      = request.payload;
    cls.kind         = ipc_mbx_pkg::K_REJECT;
    if (caller_bad) begin
      cls.early_status = ipc_mbx_pkg::ST_CAP;
    end else begin
      unique case (request.opcode)
        ipc_mbx_pkg::OP_SEND: begin
          if (target_bad || !may_send) begin
            cls.early_status = ipc_mbx_pkg::ST_CAP;
          end else if (!request.buffer_valid) begin
            cls.early_status = ipc_mbx_pkg::ST_PTR;
          end else begin
            cls.kind = ipc_mbx_pkg::K_SEND;
          end
        end
        ipc_mbx_pkg::OP_RECV, ipc_mbx_pkg::OP_POLL: begin
          if (!request.buffer_valid) begin
            cls.early_status = ipc_mbx_pkg::ST_PTR;
          end else if (request.opcode == ipc_mbx_pkg::OP_RECV) begin
            cls.kind = ipc_mbx_pkg::K_RECV;
          end else begin
            cls.kind = ipc_mbx_pkg::K_POLL;
          end
        end
        ipc_mbx_pkg::OP_START: cls.kind = ipc_mbx_pkg::K_START;
        ipc_mbx_pkg::OP_END:   cls.kind = ipc_mbx_pkg::K_END;
        default:               cls.early_status = ipc_mbx_pkg::ST_CAP;
      endcase
    end
  end

  // two-entry command queue
  ipc_mbx_pkg::cmd_t q [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        cnt;
  logic              do_push, do_pop;

  assign full      = cnt == 2'd2;
  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/ipc_mbx_back.sv =====
// ipc_mbx_back: executes classified requests against the task record RAM and
// the message RAM, holds the result register; uses ipc_mbx_pkg, ipc_mbx_ram
`timescale 1ns / 1ps

module ipc_mbx_back #(
  parameter int TASKS        = ipc_mbx_pkg::TASKS_DEF,
  parameter int QUEUE_DEPTH  = ipc_mbx_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = ipc_mbx_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  ipc_mbx_pkg::cmd_t    cmd,
  output logic                 cmd_take,
  output logic                 empty,
  input  logic                 pop,
  output ipc_mbx_pkg::result_t result
);

  localparam int TW  = $clog2(TASKS);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RW  = 2 + QW + CW + 32;
  localparam int MD  = TASKS * QUEUE_DEPTH;
  localparam int MAW = $clog2(MD);
  localparam int MW  = PAYLOAD_BITS + 5;
  localparam logic [QW+1:0] QD_S = (QW + 2)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QD_LAST = QW'(QUEUE_DEPTH - 1);

  ipc_mbx_pkg::back_state_t state, state_next;
  ipc_mbx_pkg::cmd_t        cur;
  ipc_mbx_pkg::result_t     res_next;
  logic                     out_valid, res_load;
  logic                     rec_vld [TASKS];
  logic                     rec_hit;

  // task record ram
  logic          rec_we;
  logic [RW-1:0] rec_wdata, rec_rdata;
  logic [TW-1:0] rd_subj, cur_subj;

  assign rd_subj  = cmd.subject[TW-1:0];
  assign cur_subj = cur.subject[TW-1:0];

  ipc_mbx_ram #(.WIDTH(RW), .DEPTH(TASKS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (cur_subj),
    .wdata (rec_wdata),
    .raddr (rd_subj),
    .rdata (rec_rdata)
  );

  // message ram
  logic           msg_we;
  logic [MAW-1:0] msg_waddr, msg_raddr;
  logic [MW-1:0]  msg_wdata, msg_rdata;

  ipc_mbx_ram #(.WIDTH(MW), .DEPTH(MD)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wdata),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  // record fields, reset values for never-written tasks
  logic [1:0]    r_state;
  logic [QW-1:0] r_head;
  logic [CW-1:0] r_count;
  logic [31:0]   r_saddr;

  always_comb begin
    if (rec_hit) begin
      {r_state, r_head, r_count, r_saddr} = rec_rdata;
    end else begin
      r_state = ipc_mbx_pkg::TS_DEAD;
      r_head  = '0;
      r_count = '0;
      r_saddr = '0;
    end
  end

  // ring slot arithmetic
  logic [QW+1:0]  tail_sum;
  logic [QW-1:0]  tail_slot, head_inc;
  logic [MAW-1:0] base;
  logic [63:0]    pay_m;

  always_comb begin
    tail_sum  = (QW + 2)'(r_head) + (QW + 2)'(r_count);
    tail_slot = (tail_sum >= QD_S) ? QW'(tail_sum - QD_S) : tail_sum[QW-1:0];
    head_inc  = (r_head == QD_LAST) ? '0 : r_head + 1'b1;
    base      = MAW'(cur_subj) * MAW'(QUEUE_DEPTH);
    pay_m     = 64'(cur.payload[PAYLOAD_BITS-1:0]);
  end

  // sequencer
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    rec_we     = 1'b0;
    rec_wdata  = {r_state, r_head, r_count, r_saddr};
    msg_we     = 1'b0;
    msg_waddr  = base + MAW'(tail_slot);
    msg_raddr  = base + MAW'(r_head);
    msg_wdata  = {cur.caller, cur.payload[PAYLOAD_BITS-1:0]};
    res_next.status = ipc_mbx_pkg::ST_OK;
    unique case (state)
      ipc_mbx_pkg::BS_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_take = 1'b1;
          if (cmd.kind == ipc_mbx_pkg::K_REJECT) begin
            res_load        = 1'b1;
            res_next.status = cmd.early_status;
          end else begin
            state_next = ipc_mbx_pkg::BS_EXEC;
          end
        end
      end
      ipc_mbx_pkg::BS_EXEC: begin
        state_next = ipc_mbx_pkg::BS_IDLE;
        res_load   = 1'b1;
        unique case (cur.kind)
          ipc_mbx_pkg::K_SEND: begin
            if (r_state == ipc_mbx_pkg::TS_DEAD) begin
              res_next.status = ipc_mbx_pkg::ST_DEAD;
            end else if (r_state == ipc_mbx_pkg::TS_WAIT) begin
              if (!cur.tvalid) begin
                res_next.status = ipc_mbx_pkg::ST_SAVED;
              end else begin
                rec_we                 = 1'b1;
                rec_wdata              = {ipc_mbx_pkg::TS_RUN, r_head, r_count, r_saddr};
                res_next.msg_payload   = pay_m;
                res_next.msg_sender    = cur.caller;
                res_next.woke_receiver = 1'b1;
                res_next.woke_task     = 5'(cur_subj);
                res_next.woke_address  = r_saddr;
              end
            end else if (r_count >= QD_C) begin
              res_next.status = ipc_mbx_pkg::ST_FULL;
            end else begin
              msg_we    = 1'b1;
              rec_we    = 1'b1;
              rec_wdata = {r_state, r_head, r_count + 1'b1, r_saddr};
            end
          end
          ipc_mbx_pkg::K_RECV, ipc_mbx_pkg::K_POLL: begin
            if (r_count != '0) begin
              rec_we     = 1'b1;
              rec_wdata  = {r_state, head_inc, r_count - 1'b1, r_saddr};
              res_load   = 1'b0;
              state_next = ipc_mbx_pkg::BS_MSGRD;
            end else if (cur.kind == ipc_mbx_pkg::K_POLL) begin
              res_next.status = ipc_mbx_pkg::ST_EMPTY;
            end else begin
              rec_we                  = 1'b1;
              rec_wdata               = {ipc_mbx_pkg::TS_WAIT, r_head, r_count, cur.addr};
              res_next.caller_blocked = 1'b1;
            end
          end
          ipc_mbx_pkg::K_START: begin
            rec_we    = 1'b1;
            rec_wdata = {ipc_mbx_pkg::TS_RUN, {QW{1'b0}}, {CW{1'b0}}, 32'd0};
          end
          ipc_mbx_pkg::K_END: begin
            rec_we    = 1'b1;
            rec_wdata = {ipc_mbx_pkg::TS_DEAD, r_head, r_count, r_saddr};
          end
          default: res_next.status = cur.early_status;
        endcase
      end
      ipc_mbx_pkg::BS_MSGRD: begin
        state_next           = ipc_mbx_pkg::BS_IDLE;
        res_load             = 1'b1;
        res_next.msg_payload = 64'(msg_rdata[PAYLOAD_BITS-1:0]);
        res_next.msg_sender  = msg_rdata[MW-1:PAYLOAD_BITS];
        res_next.msg_valid   = 1'b1;
      end
      default: state_next = ipc_mbx_pkg::BS_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_mbx_pkg::BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // current command, record valid lookup, result register
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur     <= cmd;
      rec_hit <= rec_vld[rd_subj];
    end
    if (res_load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        rec_vld[i] <= 1'b0;
      end
    end else begin
      if (rec_we) begin
        rec_vld[cur_subj] <= 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

`ifndef SYNTH
  // work only starts with the result register free
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != ipc_mbx_pkg::BS_IDLE) |-> !out_valid)
    else $error("back end busy while a result waits");

  // a popped message is always presented next cycle
  a_msgrd_result: assert property (@(posedge clk) disable iff (rst)
    (state == ipc_mbx_pkg::BS_MSGRD) |=> out_valid)
    else $error("message read produced no result");

  // queue count never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ipc_mbx_pkg::BS_EXEC) |-> (r_count <= QD_C))
    else $error("queue count beyond ring depth");

  // a command is only taken when idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == ipc_mbx_pkg::BS_IDLE))
    else $error("command taken while busy");
`endif

endmodule

// ===== design/ipc_mailbox_queue_engine_top.sv =====
// ipc_mailbox_queue_engine_top: top level of the per-task mailbox engine
// depends on ipc_mbx_pkg, ipc_mbx_front, ipc_mbx_back, ipc_mbx_ram
//
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------
// request   | push / full         | request (ipc_mbx_pkg::request_t)
// result    | pop / empty         | result  (ipc_mbx_pkg::result_t)
// config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a request passes through the back end as a record read and then an execute
// step; a receive that pops a message adds a read of the registered message RAM;
// a request rejected by the front end has its result loaded from the idle state.
// the back end takes no new request until its result is popped.
// synchronous active-high reset marks every task dead; no clearing pass.
// a two-entry command queue keeps taking requests, until full, while a result waits.
`timescale 1ns / 1ps

module ipc_mailbox_queue_engine_top #(
  parameter int TASKS        = ipc_mbx_pkg::TASKS_DEF,
  parameter int QUEUE_DEPTH  = ipc_mbx_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = ipc_mbx_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ipc_mbx_pkg::request_t request,
  output logic                  empty,
  input  logic                  pop,
  output ipc_mbx_pkg::result_t  result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data
);

  logic              cmd_valid, cmd_take;
  ipc_mbx_pkg::cmd_t cmd;

  // front end: config and classification
  ipc_mbx_front #(.TASKS(TASKS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back end: execution and result
  ipc_mbx_back #(
    .TASKS        (TASKS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
